/* sv/stack_machine_execute_unit_macros.svh */
// assertion macros for the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SMX_ASSERT(label, clk, rst_n, prop, msg)
`define SMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/smx_pkg.sv */
package smx_pkg;

  typedef enum logic [4:0] {
    OP_POP = 5'd0, OP_DUP = 5'd1, OP_SWAP = 5'd2, OP_RETURN = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_REM = 5'd8, OP_AND = 5'd9, OP_OR = 5'd10, OP_XOR = 5'd11,
    OP_SHL = 5'd12, OP_SHR = 5'd13, OP_BIPUSH = 5'd14, OP_ILDC = 5'd15,
    OP_NULL = 5'd16, OP_VLOAD = 5'd17, OP_VSTORE = 5'd18, OP_ATHROW = 5'd19,
    OP_ASSERT = 5'd20, OP_NOP = 5'd21, OP_CMPEQ = 5'd22, OP_CMPNE = 5'd23,
    OP_LT = 5'd24, OP_GE = 5'd25, OP_GT = 5'd26, OP_LE = 5'd27,
    OP_GOTO = 5'd28
  } opcode_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_DIV_ZERO = 4'd1, ST_DIV_OVF = 4'd2, ST_BAD_SHIFT = 4'd3,
    ST_UNDERFLOW = 4'd4, ST_OVERFLOW = 4'd5, ST_ASSERT = 4'd6, ST_THROW = 4'd7,
    ST_BAD_OP = 4'd8
  } status_e;

  localparam logic [31:0] IntMin = 32'h8000_0000;
  localparam logic [31:0] ShiftMax = 32'd31;

  typedef struct packed {
    logic [4:0]  opcode;
    logic signed [15:0] immediate;
    logic [7:0]  local_index;
    logic signed [31:0] pool_constant;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic signed [15:0] pc_delta;
    logic        branch_taken;
    logic        returned;
    logic signed [31:0] return_value;
    logic        halted;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic        want_rem;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

  function automatic logic [1:0] need_of(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op)
      OP_POP, OP_DUP, OP_RETURN, OP_VSTORE, OP_ATHROW: n = 2'd1;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR,
      OP_SHL, OP_SHR, OP_ASSERT, OP_CMPEQ, OP_CMPNE, OP_LT, OP_GE, OP_GT,
      OP_LE: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] give_of(input logic [4:0] op);
    logic [1:0] g;
    g = 2'd0;
    case (op)
      OP_DUP, OP_SWAP: g = 2'd2;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR, OP_SHL,
      OP_SHR, OP_BIPUSH, OP_ILDC, OP_NULL, OP_VLOAD: g = 2'd1;
      default: g = 2'd0;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] len_of(input logic [4:0] op);
    logic [1:0] l;
    l = 2'd1;
    case (op)
      OP_BIPUSH, OP_VLOAD, OP_VSTORE: l = 2'd2;
      OP_ILDC, OP_CMPEQ, OP_CMPNE, OP_LT, OP_GE, OP_GT, OP_LE, OP_GOTO: l = 2'd3;
      default: l = 2'd1;
    endcase
    return l;
  endfunction

endpackage

/* sv/smx_stream_if.sv */
interface smx_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/smx_ram.sv */
module smx_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/smx_divider.sv */
module smx_divider import smx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d, rsel_q, rsel_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [31:0] a_abs, b_abs, q_fix, r_fix;

  assign a_abs = req_i.dividend[31] ? (~req_i.dividend + 32'd1) : req_i.dividend;
  assign b_abs = req_i.divisor[31] ? (~req_i.divisor + 32'd1) : req_i.divisor;
  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dsr_q};
  assign q_fix = qneg_q ? (~quo_q + 32'd1) : quo_q;
  assign r_fix = rneg_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    rsel_d = rsel_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      quo_d  = a_abs;
      rem_d  = '0;
      dsr_d  = b_abs;
      qneg_d = req_i.dividend[31] ^ req_i.divisor[31];
      rneg_d = req_i.dividend[31];
      rsel_d = req_i.want_rem;
    end else if (busy_q) begin
      // one restoring step per cycle
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
    rsel_q <= rsel_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = rsel_q ? r_fix : q_fix;
endmodule

/* sv/stack_machine_execute_unit.sv */
// Stack machine execute unit: runs one decoded bytecode instruction per request
// on an operand stack and a locals store, both held in single-port-read
// synchronous RAMs. An instruction passes through accept, read the top entry
// and the local, read the second entry, execute and write back, and answer; div
// and rem also wait on the radix-2 divider. After reset the locals are cleared
// one after another by a pass during which no request is taken. Any
// error or a return halts the unit until reset; later requests answer halted.
module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int LOCAL_COUNT = 256
) (
  input logic           clk_i,
  input logic           rst_ni,
  smx_stream_if.sink    in_i,
  smx_stream_if.source  out_o
);
`include "stack_machine_execute_unit_macros.svh"

  localparam int SpW = $clog2(STACK_DEPTH + 1);
  localparam int SaW = $clog2(STACK_DEPTH);
  localparam int LaW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int LcW = $clog2(LOCAL_COUNT + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_OUT
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  rsp_t   rsp_q, rsp_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic           halt_q, halt_d;
  logic [LcW-1:0] clr_q, clr_d;
  logic [31:0]    x_q, x_d;

  // stack ram
  logic           st_we;
  logic [SaW-1:0] st_waddr, st_raddr;
  logic [31:0]    st_wdata, st_rdata;
  // merged stack write port
  logic           st_we_f;
  logic [SaW-1:0] st_waddr_f;
  logic [31:0]    st_wdata_f;
  // locals ram
  logic           lc_we;
  logic [LaW-1:0] lc_waddr, lc_raddr;
  logic [31:0]    lc_wdata, lc_rdata;
  logic [31:0]    lv_q, lv_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  smx_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(st_we_f), .waddr_i(st_waddr_f), .wdata_i(st_wdata_f),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  smx_ram #(.Width(32), .Depth(LOCAL_COUNT)) u_locals (
    .clk_i, .we_i(lc_we), .waddr_i(lc_waddr), .wdata_i(lc_wdata),
    .raddr_i(lc_raddr), .rdata_o(lc_rdata)
  );

  smx_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  logic [1:0] need, give;
  logic       idx_ok;
  logic [31:0] y, res;
  logic        take, wr_res;
  logic [SpW:0] sp_after;

  assign need   = need_of(req_q.opcode);
  assign give   = give_of(req_q.opcode);
  assign idx_ok = ({1'b0, req_q.local_index} < 9'(LOCAL_COUNT));
  assign y      = st_rdata;
  assign sp_after = {1'b0, sp_q} - (SpW+1)'(need) + (SpW+1)'(give);

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = rsp_q;

  function automatic rsp_t mk(input status_e st, input logic h);
    rsp_t r;
    r = '0;
    r.status = st;
    r.halted = h;
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    rsp_d   = rsp_q;
    sp_d    = sp_q;
    halt_d  = halt_q;
    clr_d   = clr_q;
    x_d     = x_q;
    lv_d    = lv_q;
    st_we   = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_raddr = SaW'(sp_q - SpW'(1));
    lc_we    = 1'b0;
    lc_waddr = LaW'(clr_q);
    lc_wdata = '0;
    lc_raddr = LaW'(req_q.local_index);
    div_req  = '0;
    res      = '0;
    take     = 1'b0;
    wr_res   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // zero one local per cycle
        lc_we = 1'b1;
        clr_d = clr_q + LcW'(1);
        if (clr_q == LcW'(LOCAL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.data;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        // top of stack and local slot are read this cycle
        st_raddr = SaW'(sp_q - SpW'(1));
        state_d  = S_RD2;
      end
      S_RD2: begin
        x_d      = st_rdata;
        lv_d     = idx_ok ? lc_rdata : 32'd0;
        st_raddr = SaW'(sp_q - SpW'(2));
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
        rsp_d   = mk(ST_OK, 1'b0);
        rsp_d.pc_delta = 16'(len_of(req_q.opcode));
        if (halt_q) begin
          rsp_d = mk(ST_OK, 1'b1);
        end else if (req_q.opcode > OP_GOTO) begin
          rsp_d = mk(ST_BAD_OP, 1'b1);
          halt_d = 1'b1;
        end else if ({1'b0, sp_q} < (SpW+1)'(need)) begin
          rsp_d = mk(ST_UNDERFLOW, 1'b1);
          halt_d = 1'b1;
        end else if (sp_after > (SpW+1)'(STACK_DEPTH)) begin
          rsp_d = mk(ST_OVERFLOW, 1'b1);
          halt_d = 1'b1;
        end else begin
          case (req_q.opcode)
            OP_POP: sp_d = sp_q - SpW'(1);
            OP_DUP: begin
              st_we = 1'b1; st_waddr = SaW'(sp_q); st_wdata = x_q;
              sp_d = sp_q + SpW'(1);
            end
            OP_SWAP: begin
              // second write of the pair goes out in S_OUT
              st_we = 1'b1; st_waddr = SaW'(sp_q - SpW'(1)); st_wdata = y;
              x_d = x_q;
            end
            OP_RETURN: begin
              rsp_d = mk(ST_OK, 1'b1);
              rsp_d.returned = 1'b1;
              rsp_d.return_value = x_q;
              sp_d = sp_q - SpW'(1);
              halt_d = 1'b1;
            end
            OP_DIV, OP_REM: begin
              if (x_q == 32'd0) begin
                rsp_d = mk(ST_DIV_ZERO, 1'b1); halt_d = 1'b1;
              end else if (x_q == 32'hFFFF_FFFF && y == IntMin) begin
                rsp_d = mk(ST_DIV_OVF, 1'b1); halt_d = 1'b1;
              end else begin
                div_req.start    = 1'b1;
                div_req.want_rem = (req_q.opcode == OP_REM);
                div_req.dividend = y;
                div_req.divisor  = x_q;
                state_d = S_DIV;
              end
            end
            OP_SHL, OP_SHR: begin
              if (x_q > ShiftMax) begin
                rsp_d = mk(ST_BAD_SHIFT, 1'b1); halt_d = 1'b1;
              end else begin
                res = (req_q.opcode == OP_SHL) ? (y << x_q[4:0])
                                               : 32'($signed(y) >>> x_q[4:0]);
                wr_res = 1'b1;
              end
            end
            OP_ADD: begin res = y + x_q; wr_res = 1'b1; end
            OP_SUB: begin res = y - x_q; wr_res = 1'b1; end
            OP_MUL: begin res = y * x_q; wr_res = 1'b1; end
            OP_AND: begin res = y & x_q; wr_res = 1'b1; end
            OP_OR:  begin res = y | x_q; wr_res = 1'b1; end
            OP_XOR: begin res = y ^ x_q; wr_res = 1'b1; end
            OP_BIPUSH, OP_ILDC, OP_NULL, OP_VLOAD: begin
              st_we = 1'b1; st_waddr = SaW'(sp_q);
              case (req_q.opcode)
                OP_BIPUSH: st_wdata = {{24{req_q.immediate[7]}}, req_q.immediate[7:0]};
                OP_ILDC:   st_wdata = req_q.pool_constant;
                OP_VLOAD:  st_wdata = lv_q;
                default:   st_wdata = 32'd0;
              endcase
              sp_d = sp_q + SpW'(1);
            end
            OP_VSTORE: begin
              lc_we = idx_ok; lc_waddr = LaW'(req_q.local_index); lc_wdata = x_q;
              sp_d = sp_q - SpW'(1);
            end
            OP_ATHROW: begin rsp_d = mk(ST_THROW, 1'b1); halt_d = 1'b1; end
            OP_ASSERT: begin
              if (y == 32'd0) begin
                rsp_d = mk(ST_ASSERT, 1'b1); halt_d = 1'b1;
              end else begin
                sp_d = sp_q - SpW'(2);
              end
            end
            OP_NOP: ;
            OP_GOTO: take = 1'b1;
            default: begin
              case (req_q.opcode)
                OP_CMPEQ: take = (y == x_q);
                OP_CMPNE: take = (y != x_q);
                OP_LT:    take = ($signed(y) <  $signed(x_q));
                OP_GE:    take = ($signed(y) >= $signed(x_q));
                OP_GT:    take = ($signed(y) >  $signed(x_q));
                default:  take = ($signed(y) <= $signed(x_q));
              endcase
              sp_d = sp_q - SpW'(2);
            end
          endcase
          if (wr_res) begin
            st_we = 1'b1; st_waddr = SaW'(sp_q - SpW'(2)); st_wdata = res;
            sp_d = sp_q - SpW'(1);
          end
          if (take) begin
            rsp_d.pc_delta = req_q.immediate;
            rsp_d.branch_taken = 1'b1;
          end
        end
        // hold the second operand in lv_q for a swap; the S_OUT write takes x_q
        lv_d = (req_q.opcode == OP_SWAP) ? y : lv_q;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          st_we = 1'b1; st_waddr = SaW'(sp_q - SpW'(2)); st_wdata = div_rsp.result;
          sp_d = sp_q - SpW'(1);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // swap finishes its second write while the result waits
  logic swap_wr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_wr_q <= 1'b0;
    end else begin
      swap_wr_q <= (state_q == S_EXEC) && st_we && (req_q.opcode == OP_SWAP);
    end
  end

  always_comb begin
    st_we_f    = st_we;
    st_waddr_f = st_waddr;
    st_wdata_f = st_wdata;
    if (swap_wr_q) begin
      st_we_f    = 1'b1;
      st_waddr_f = SaW'(sp_q - SpW'(2));
      st_wdata_f = x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sp_q    <= '0;
      halt_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      halt_q  <= halt_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    x_q   <= x_d;
    lv_q  <= lv_d;
  end

  `SMX_ASSERT_IMP(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= SpW'(STACK_DEPTH), "sp out of range")
  `SMX_ASSERT_IMP(a_halt_sticky, clk_i, rst_ni, halt_q, ##1 halt_q, "halt cleared")
  `SMX_ASSERT_IMP(a_out_halt, clk_i, rst_ni, out_o.valid && rsp_q.status != ST_OK, rsp_q.halted, "error without halt")
  `SMX_ASSERT_IMP(a_no_take_clear, clk_i, rst_ni, state_q == S_CLEAR, !in_i.ready, "request during clear")
endmodule
